// ----- hdl/vlmc_pkg.sv -----
// Shared types and constants for the video line mosaic control unit.
package vlmc_pkg;

   localparam int NUM_LAYERS  = 4;
   localparam int LAYER_SLOTS = 4;

   localparam logic [8:0] LINE_CLEAR           = 9'd0;
   localparam logic [8:0] LINE_MOSAIC_RESET    = 9'd1;
   localparam logic [8:0] RELOAD_LINE_NORMAL   = 9'd225;
   localparam logic [8:0] RELOAD_LINE_OVERSCAN = 9'd240;
   localparam logic [7:0] LAST_LINE_NORMAL     = 8'd224;
   localparam logic [7:0] LAST_LINE_OVERSCAN   = 8'd239;

   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;

   typedef enum logic [0:0] {
      OP_SCANLINE = 1'b0,
      OP_FRAME    = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      CSR_MOSAIC_SPAN        = 3'd0,
      CSR_MOSAIC_LAYER_MASK  = 3'd1,
      CSR_OVERSCAN_MODE      = 3'd2,
      CSR_DISPLAY_OFF        = 3'd3,
      CSR_SPRITE_BASE_WORD   = 3'd4,
      CSR_SPRITE_ROTATION_ON = 3'd5,
      CSR_INTERLACE_REQUEST  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [0:0] opcode;
      logic [8:0] line_number;
   } req_payload_type;

   typedef struct packed {
      logic [8:0] layer0_line;
      logic [8:0] layer1_line;
      logic [8:0] layer2_line;
      logic [8:0] layer3_line;
      logic       overflow_clear;
      logic [9:0] sprite_addr;
      logic       sprite_addr_reloaded;
      logic [6:0] first_sprite;
      logic       field_odd;
      logic       interlace_active;
      logic [7:0] last_line;
   } rsp_payload_type;

   typedef struct packed {
      logic [3:0] mosaic_span;
      logic [3:0] mosaic_layer_mask;
      logic       overscan_mode;
      logic       display_off;
      logic [8:0] sprite_base_word;
      logic       sprite_rotation_on;
      logic       interlace_request;
   } cfg_type;

endpackage

// ----- hdl/vlmc_csr.sv -----
// APB-style configuration register file.
module vlmc_csr import vlmc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready,
   output cfg_type                   cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          write_en;

   assign index    = csr_index_type'(paddr[CSR_ADDR_WIDTH-1:2]);
   assign write_en = psel & penable & pwrite;
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            CSR_MOSAIC_SPAN:        cfg_in.mosaic_span        = pwdata[3:0];
            CSR_MOSAIC_LAYER_MASK:  cfg_in.mosaic_layer_mask  = pwdata[3:0];
            CSR_OVERSCAN_MODE:      cfg_in.overscan_mode      = pwdata[0];
            CSR_DISPLAY_OFF:        cfg_in.display_off        = pwdata[0];
            CSR_SPRITE_BASE_WORD:   cfg_in.sprite_base_word   = pwdata[8:0];
            CSR_SPRITE_ROTATION_ON: cfg_in.sprite_rotation_on = pwdata[0];
            CSR_INTERLACE_REQUEST:  cfg_in.interlace_request  = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (index)
         CSR_MOSAIC_SPAN:        prdata[3:0] = cfg_ff.mosaic_span;
         CSR_MOSAIC_LAYER_MASK:  prdata[3:0] = cfg_ff.mosaic_layer_mask;
         CSR_OVERSCAN_MODE:      prdata[0]   = cfg_ff.overscan_mode;
         CSR_DISPLAY_OFF:        prdata[0]   = cfg_ff.display_off;
         CSR_SPRITE_BASE_WORD:   prdata[8:0] = cfg_ff.sprite_base_word;
         CSR_SPRITE_ROTATION_ON: prdata[0]   = cfg_ff.sprite_rotation_on;
         CSR_INTERLACE_REQUEST:  prdata[0]   = cfg_ff.interlace_request;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{display_off: 1'b1, default: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- hdl/vlmc_core.sv -----
// Event pipeline: input register, line/frame state update, result register.
module vlmc_core import vlmc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            in_valid,
   output logic            in_ready,
   input  req_payload_type in_data,
   output logic            out_valid,
   input  logic            out_ready,
   output rsp_payload_type out_data
);

   logic            stage_valid_ff;
   logic            stage_valid_in;
   req_payload_type stage_data_ff;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type rsp_data_in;

   logic [4:0] mosaic_count_ff;
   logic [4:0] mosaic_count_in;
   logic [8:0] layer_line_ff [LAYER_SLOTS];
   logic [8:0] layer_line_in [LAYER_SLOTS];
   logic [9:0] sprite_address_ff;
   logic [9:0] sprite_address_in;
   logic [6:0] first_sprite_ff;
   logic [6:0] first_sprite_in;
   logic       field_parity_ff;
   logic       field_parity_in;
   logic       interlace_ff;
   logic       interlace_in;
   logic [7:0] last_line_ff;
   logic [7:0] last_line_in;

   logic       advance;
   logic       scan;
   logic       expired;
   logic       reload;
   logic [8:0] y;
   logic [8:0] reload_line;

   assign advance        = stage_valid_ff & (~rsp_valid_ff | out_ready);
   assign in_ready       = ~stage_valid_ff | advance;
   assign stage_valid_in = (in_valid & in_ready) | (stage_valid_ff & ~advance);
   assign rsp_valid_in   = advance | (rsp_valid_ff & ~out_ready);
   assign out_valid      = rsp_valid_ff;
   assign out_data       = rsp_data_ff;

   assign y           = stage_data_ff.line_number;
   assign scan        = (opcode_type'(stage_data_ff.opcode) == OP_SCANLINE);
   assign expired     = (mosaic_count_ff == 5'd0);
   assign reload_line = cfg.overscan_mode ? RELOAD_LINE_OVERSCAN : RELOAD_LINE_NORMAL;
   assign reload      = scan & (y == reload_line) & ~cfg.display_off;

   always_comb begin
      mosaic_count_in   = mosaic_count_ff;
      layer_line_in     = layer_line_ff;
      sprite_address_in = sprite_address_ff;
      first_sprite_in   = first_sprite_ff;
      field_parity_in   = field_parity_ff;
      interlace_in      = interlace_ff;
      last_line_in      = last_line_ff;
      if (advance) begin
         if (scan) begin
            if (y == LINE_MOSAIC_RESET) begin
               for (int n = 0; n < LAYER_SLOTS; n++) begin
                  if (n < NUM_LAYERS) layer_line_in[n] = LINE_MOSAIC_RESET;
               end
               mosaic_count_in = {1'b0, cfg.mosaic_span};
            end else begin
               for (int n = 0; n < LAYER_SLOTS; n++) begin
                  if (n < NUM_LAYERS && (~cfg.mosaic_layer_mask[n] | expired)) begin
                     layer_line_in[n] = y;
                  end
               end
               mosaic_count_in = expired ? {1'b0, cfg.mosaic_span} : mosaic_count_ff - 5'd1;
            end
            if (reload) begin
               sprite_address_in = {cfg.sprite_base_word, 1'b0};
               first_sprite_in   = cfg.sprite_rotation_on ? cfg.sprite_base_word[7:1] : 7'd0;
            end
         end else begin
            field_parity_in = ~field_parity_ff;
            if (field_parity_ff) begin
               interlace_in = cfg.interlace_request;
               last_line_in = cfg.overscan_mode ? LAST_LINE_OVERSCAN : LAST_LINE_NORMAL;
            end
         end
      end
   end

   always_comb begin
      rsp_data_in.layer0_line          = layer_line_in[0];
      rsp_data_in.layer1_line          = layer_line_in[1];
      rsp_data_in.layer2_line          = layer_line_in[2];
      rsp_data_in.layer3_line          = layer_line_in[3];
      rsp_data_in.overflow_clear       = scan & (y == LINE_CLEAR);
      rsp_data_in.sprite_addr          = sprite_address_in;
      rsp_data_in.sprite_addr_reloaded = reload;
      rsp_data_in.first_sprite         = first_sprite_in;
      rsp_data_in.field_odd            = field_parity_in;
      rsp_data_in.interlace_active     = interlace_in;
      rsp_data_in.last_line            = last_line_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff    <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         mosaic_count_ff   <= '0;
         layer_line_ff     <= '{default: '0};
         sprite_address_ff <= '0;
         first_sprite_ff   <= '0;
         field_parity_ff   <= 1'b0;
         interlace_ff      <= 1'b0;
         last_line_ff      <= LAST_LINE_NORMAL;
      end else begin
         stage_valid_ff    <= stage_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
         mosaic_count_ff   <= mosaic_count_in;
         layer_line_ff     <= layer_line_in;
         sprite_address_ff <= sprite_address_in;
         first_sprite_ff   <= first_sprite_in;
         field_parity_ff   <= field_parity_in;
         interlace_ff      <= interlace_in;
         last_line_ff      <= last_line_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid & in_ready) begin
         stage_data_ff <= in_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ----- hdl/video_line_mosaic_control_unit.sv -----
// Top level of the video line mosaic control unit.
//
// Events (scanline start with line number, or end of frame) enter on the
// req_ valid/ready channel; one result per event leaves on the rsp_ channel
// carrying the four layer source lines, sprite table address, first sprite,
// overflow clear strobe and field/interlace/last-line status.
// The event sits in the input register, then the state update feeds the result
// register, which drives rsp_valid and rsp_data until the result is taken.
// One event is taken every cycle while the receiver does not stall; the rate is
// set by the state update loop, which is combinational between the registers.
// When the receiver stalls, the result register holds and one more event
// is kept in the input register; req_ready then drops until rsp_ready.
// Configuration is written through the APB-style port (pready always high);
// the user must do so only while no events are in flight; the block does not check.
// Reset clears both pipeline stages and all line, sprite and field state;
// display_off resets to one and the last line to 224.
module video_line_mosaic_control_unit import vlmc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_payload_type           req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_payload_type           rsp_data,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   cfg_type cfg;

   vlmc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   vlmc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

// ----- sim/tb_video_line_mosaic_control_unit.sv -----
// Self-checking testbench for the video line mosaic control unit.
module tb_video_line_mosaic_control_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import vlmc_pkg::*;

   localparam int STALL_LIMIT   = 2000;
   localparam int PHASE_EVENTS  = 135;
   localparam int RANDOM_PHASES = 8;

   class line_ctrl_scoreboard;
      cfg_type         cfg;
      logic [4:0]      mosaic_count;
      logic [8:0]      layer_line[LAYER_SLOTS];
      logic [9:0]      sprite_address;
      logic [6:0]      first_sprite_index;
      logic            field_parity;
      logic            interlace_latched;
      logic [7:0]      last_line_latched;
      rsp_payload_type expected_results[$];
      int              errors;
      int              events_in;
      int              results_checked;
      int              reloads_seen;
      int              frames_seen;

      function new();
         cfg = '0;
         cfg.display_off = 1'b1;
         mosaic_count = '0;
         foreach (layer_line[n]) layer_line[n] = '0;
         sprite_address = '0;
         first_sprite_index = '0;
         field_parity = 1'b0;
         interlace_latched = 1'b0;
         last_line_latched = LAST_LINE_NORMAL;
         errors = 0;
         events_in = 0;
         results_checked = 0;
         reloads_seen = 0;
         frames_seen = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [31:0] value);
         case (idx)
            CSR_MOSAIC_SPAN:        cfg.mosaic_span        = value[3:0];
            CSR_MOSAIC_LAYER_MASK:  cfg.mosaic_layer_mask  = value[3:0];
            CSR_OVERSCAN_MODE:      cfg.overscan_mode      = value[0];
            CSR_DISPLAY_OFF:        cfg.display_off        = value[0];
            CSR_SPRITE_BASE_WORD:   cfg.sprite_base_word   = value[8:0];
            CSR_SPRITE_ROTATION_ON: cfg.sprite_rotation_on = value[0];
            CSR_INTERLACE_REQUEST:  cfg.interlace_request  = value[0];
            default: ;
         endcase
      endfunction

      function void predict_event(req_payload_type ev);
         rsp_payload_type r;
         logic            expired;
         logic            cleared;
         logic            reloaded;
         logic [8:0]      y;
         logic [8:0]      reload_line;
         cleared = 1'b0;
         reloaded = 1'b0;
         y = ev.line_number;
         events_in++;
         if (ev.opcode == OP_SCANLINE) begin
            expired = (mosaic_count == 5'd0);
            cleared = (y == LINE_CLEAR);
            if (y == LINE_MOSAIC_RESET) begin
               for (int n = 0; n < NUM_LAYERS; n++) layer_line[n] = 9'd1;
               mosaic_count = {1'b0, cfg.mosaic_span};
            end else begin
               for (int n = 0; n < NUM_LAYERS; n++) begin
                  if (!cfg.mosaic_layer_mask[n] || expired) layer_line[n] = y;
               end
               if (expired) mosaic_count = {1'b0, cfg.mosaic_span} + 5'd1;
               mosaic_count = mosaic_count - 5'd1;
            end
            reload_line = cfg.overscan_mode ? RELOAD_LINE_OVERSCAN : RELOAD_LINE_NORMAL;
            if (y == reload_line && !cfg.display_off) begin
               sprite_address = {cfg.sprite_base_word, 1'b0};
               first_sprite_index = cfg.sprite_rotation_on ? sprite_address[8:2] : 7'd0;
               reloaded = 1'b1;
            end
         end else begin
            frames_seen++;
            field_parity = ~field_parity;
            if (!field_parity) begin
               interlace_latched = cfg.interlace_request;
               last_line_latched = cfg.overscan_mode ? LAST_LINE_OVERSCAN : LAST_LINE_NORMAL;
            end
         end
         r.layer0_line          = layer_line[0];
         r.layer1_line          = layer_line[1];
         r.layer2_line          = layer_line[2];
         r.layer3_line          = layer_line[3];
         r.overflow_clear       = cleared;
         r.sprite_addr          = sprite_address;
         r.sprite_addr_reloaded = reloaded;
         r.first_sprite         = first_sprite_index;
         r.field_odd            = field_parity;
         r.interlace_active     = interlace_latched;
         r.last_line            = last_line_latched;
         expected_results.push_back(r);
      endfunction

      task report_mismatch(string what, logic [31:0] got_v, logic [31:0] exp_v);
         errors++;
         if (errors <= 40)
            $display("[%0t] mismatch on result %0d, %s: got %0d, expected %0d",
                     $realtime, results_checked, what, got_v, exp_v);
      endtask

      task compare_result(rsp_payload_type got);
         rsp_payload_type exp;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected transfer", 32'd1, 32'd0);
         end else begin
            exp = expected_results.pop_front();
            if (got.layer0_line !== exp.layer0_line)
               report_mismatch("layer0_line", 32'(got.layer0_line), 32'(exp.layer0_line));
            if (got.layer1_line !== exp.layer1_line)
               report_mismatch("layer1_line", 32'(got.layer1_line), 32'(exp.layer1_line));
            if (got.layer2_line !== exp.layer2_line)
               report_mismatch("layer2_line", 32'(got.layer2_line), 32'(exp.layer2_line));
            if (got.layer3_line !== exp.layer3_line)
               report_mismatch("layer3_line", 32'(got.layer3_line), 32'(exp.layer3_line));
            if (got.overflow_clear !== exp.overflow_clear)
               report_mismatch("overflow_clear", 32'(got.overflow_clear),
                               32'(exp.overflow_clear));
            if (got.sprite_addr !== exp.sprite_addr)
               report_mismatch("sprite_addr", 32'(got.sprite_addr), 32'(exp.sprite_addr));
            if (got.sprite_addr_reloaded !== exp.sprite_addr_reloaded)
               report_mismatch("sprite_addr_reloaded", 32'(got.sprite_addr_reloaded),
                               32'(exp.sprite_addr_reloaded));
            if (got.first_sprite !== exp.first_sprite)
               report_mismatch("first_sprite", 32'(got.first_sprite), 32'(exp.first_sprite));
            if (got.field_odd !== exp.field_odd)
               report_mismatch("field_odd", 32'(got.field_odd), 32'(exp.field_odd));
            if (got.interlace_active !== exp.interlace_active)
               report_mismatch("interlace_active", 32'(got.interlace_active),
                               32'(exp.interlace_active));
            if (got.last_line !== exp.last_line)
               report_mismatch("last_line", 32'(got.last_line), 32'(exp.last_line));
            if (exp.sprite_addr_reloaded) reloads_seen++;
         end
         results_checked++;
      endtask
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   req_payload_type           req_data;
   logic                      rsp_valid;
   logic                      rsp_ready;
   rsp_payload_type           rsp_data;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [CSR_DATA_WIDTH-1:0] pwdata;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   line_ctrl_scoreboard sb = new();

   bit gaps_on = 1'b1;
   int holdoff_request = 0;
   int stall_cycles = 0;
   int config_phases = 0;
   int events_sent = 0;

   video_line_mosaic_control_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // transfer monitor: results are checked before new events are predicted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.compare_result(rsp_data);
         if (req_valid && req_ready) sb.predict_event(req_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
         $display("tb: failure");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (holdoff_request > 0) begin
            hold_left = holdoff_request;
            holdoff_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= gaps_on ? ($urandom_range(0, 99) >= 27) : 1'b1;
         end
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_item(input req_payload_type item);
      if (gaps_on) begin
         while ($urandom_range(0, 99) < 27) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      events_sent++;
      @(negedge clock);
   endtask

   task automatic send_event(input opcode_type op, input logic [8:0] line);
      req_payload_type item;
      item.opcode = op;
      item.line_number = line;
      send_item(item);
   endtask

   task automatic send_scanline(input logic [8:0] line);
      if ($urandom_range(0, 99) < 12)
         send_event(opcode_type'($urandom_range(0, 1)), 9'($urandom_range(0, 511)));
      else
         send_event(OP_SCANLINE, line);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_WIDTH'({idx, 2'b00});
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_register(idx, value);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic program_all(input cfg_type c);
      write_csr(CSR_MOSAIC_SPAN,        32'(c.mosaic_span));
      write_csr(CSR_MOSAIC_LAYER_MASK,  32'(c.mosaic_layer_mask));
      write_csr(CSR_OVERSCAN_MODE,      32'(c.overscan_mode));
      write_csr(CSR_DISPLAY_OFF,        32'(c.display_off));
      write_csr(CSR_SPRITE_BASE_WORD,   32'(c.sprite_base_word));
      write_csr(CSR_SPRITE_ROTATION_ON, 32'(c.sprite_rotation_on));
      write_csr(CSR_INTERLACE_REQUEST,  32'(c.interlace_request));
      config_phases++;
   endtask

   // top lines with mosaic countdown, a run across the blank line, then a frame end
   task automatic send_frame_burst();
      int top_end;
      int blank_start;
      int blank_len;
      top_end = $urandom_range(3, 24);
      blank_start = $urandom_range(218, 244);
      blank_len = $urandom_range(4, 12);
      for (int y = 0; y <= top_end; y++) send_scanline(9'(y));
      for (int y = blank_start; y <= blank_start + blank_len; y++) send_scanline(9'(y));
      if ($urandom_range(0, 3) == 0) send_scanline(9'($urandom_range(245, 311)));
      send_event(OP_FRAME, 9'($urandom_range(0, 511)));
   endtask

   initial begin
      cfg_type c;
      int phase_start;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: display forced off, no mosaic
      send_event(OP_SCANLINE, 9'd0);
      send_event(OP_SCANLINE, 9'd1);
      send_event(OP_SCANLINE, 9'd2);
      send_event(OP_SCANLINE, RELOAD_LINE_NORMAL);
      send_event(OP_SCANLINE, 9'd511);
      send_event(OP_SCANLINE, 9'd312);
      send_event(OP_FRAME, 9'd0);
      send_event(OP_FRAME, 9'd511);
      drain();

      // mosaic on all layers, largest block, reload with rotation, overscan
      c = '{mosaic_span: 4'd15, mosaic_layer_mask: 4'hF, overscan_mode: 1'b1,
            display_off: 1'b0, sprite_base_word: 9'd511, sprite_rotation_on: 1'b1,
            interlace_request: 1'b1};
      program_all(c);
      send_event(OP_SCANLINE, 9'd0);
      send_event(OP_SCANLINE, 9'd1);
      for (int y = 2; y < 20; y++) send_event(OP_SCANLINE, 9'(y));
      send_event(OP_SCANLINE, RELOAD_LINE_NORMAL);
      send_event(OP_SCANLINE, RELOAD_LINE_OVERSCAN);
      send_event(OP_FRAME, 9'd0);
      send_event(OP_FRAME, 9'd0);
      drain();

      // partial mask, no rotation, normal blank line
      c = '{mosaic_span: 4'd2, mosaic_layer_mask: 4'h5, overscan_mode: 1'b0,
            display_off: 1'b0, sprite_base_word: 9'd170, sprite_rotation_on: 1'b0,
            interlace_request: 1'b0};
      program_all(c);
      for (int y = 0; y < 8; y++) send_event(OP_SCANLINE, 9'(y));
      send_event(OP_SCANLINE, RELOAD_LINE_OVERSCAN);
      send_event(OP_SCANLINE, RELOAD_LINE_NORMAL);
      send_event(OP_FRAME, 9'd0);
      send_event(OP_FRAME, 9'd0);
      drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 0) begin
            c = '0;
         end else if (p == 1) begin
            c = '1;
         end else begin
            c.mosaic_span        = 4'($urandom_range(0, 15));
            c.mosaic_layer_mask  = 4'($urandom_range(0, 15));
            c.overscan_mode      = 1'($urandom_range(0, 1));
            c.display_off        = ($urandom_range(0, 3) == 0);
            c.sprite_base_word   = 9'($urandom_range(0, 511));
            c.sprite_rotation_on = 1'($urandom_range(0, 1));
            c.interlace_request  = 1'($urandom_range(0, 1));
         end
         program_all(c);
         gaps_on = (p != 3);
         if (p == 5) holdoff_request = 80;
         phase_start = events_sent;
         while (events_sent - phase_start < PHASE_EVENTS) send_frame_burst();
         drain();
      end

      gaps_on = 1'b1;
      repeat (8) @(posedge clock);
      while (sb.expected_results.size() != 0) begin
         void'(sb.expected_results.pop_front());
         sb.report_mismatch("missing result", 32'd0, 32'd1);
      end
      $display("summary: %0d events, %0d results checked, %0d frame ends, %0d sprite reloads",
               sb.events_in, sb.results_checked, sb.frames_seen, sb.reloads_seen);
      $display("summary: %0d register settings, %0d mismatches", config_phases, sb.errors);
      if (sb.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
